/* rtl/ilir_pkg.sv */
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and codes for the indexed list block: request codes, status
// codes, cell commands and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

   localparam int WORD_W   = 32;
   localparam int POS_W    = 8;
   localparam int REQ_W    = 3;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int GROUP_N  = 8;   // cells per first-level gather group

   typedef enum logic [REQ_W-1:0] {
      REQ_APPEND   = 3'd0,
      REQ_INSERT   = 3'd1,
      REQ_REMOVE   = 3'd2,
      REQ_POP_AT   = 3'd3,
      REQ_POP_LAST = 3'd4,
      REQ_READ     = 3'd5,
      REQ_WRITE    = 3'd6
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_INSERT,
      CELL_DROP
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        rd;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_GATHER,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

/* rtl/ilir_cell.sv */
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot. Holds one word, loads from the request, from the slot below
// (insert) or from the slot above (remove), and offers its word when hit.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_cell #(
   parameter int IDX_W    = 6,
   parameter int CELL_IDX = 0
) (
   input  wire                          clock,
   input  ilir_pkg::cell_cmd_type       cmd,
   input  wire  [IDX_W-1:0]             pos,
   input  wire  signed [31:0]           word,
   input  wire  signed [31:0]           below,
   input  wire  signed [31:0]           above,
   output logic signed [31:0]           entry,
   output logic signed [31:0]           sel
);
   import ilir_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic signed [WORD_W-1:0] entry_ff, entry_in;
   logic signed [WORD_W-1:0] sel_ff, sel_in;
   logic                     hit;
   logic                     past_pos;

   always_comb begin
      hit      = (pos == MY_IDX);
      past_pos = (MY_IDX > pos);
      entry_in = entry_ff;
      case (cmd.op)
         CELL_LOAD: begin
            if (hit) entry_in = word;
         end
         CELL_INSERT: begin
            if (past_pos) entry_in = below;
            else if (hit) entry_in = word;
         end
         CELL_DROP: begin
            if (hit || past_pos) entry_in = above;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
      // old value is captured, so a pop sees the entry before it moves
      sel_in = (cmd.rd && hit) ? entry_ff : '0;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      sel_ff   <= sel_in;
   end

   assign entry = entry_ff;
   assign sel   = sel_ff;

endmodule

`default_nettype wire

/* rtl/ilir_gather.sv */
// ----------------------------------------------------------------------------
// ilir_gather
// Two-level OR tree over the gated cell outputs. Only the hit cell drives a
// nonzero word, so the OR returns it; the first level is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_gather #(
   parameter int CAPACITY = 64
) (
   input  wire                              clock,
   input  wire                              load,
   input  wire  [CAPACITY-1:0][31:0]        sel,
   output logic signed [31:0]               word
);
   import ilir_pkg::*;

   localparam int GROUPS = (CAPACITY + GROUP_N - 1) / GROUP_N;

   logic [GROUPS-1:0][WORD_W-1:0] grp_ff, grp_in;

   always_comb begin
      grp_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int j = 0; j < GROUP_N; j++) begin
            if (g * GROUP_N + j < CAPACITY) grp_in[g] = grp_in[g] | sel[g * GROUP_N + j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) grp_ff <= grp_in;
   end

   always_comb begin
      word = '0;
      for (int g = 0; g < GROUPS; g++) word = word | grp_ff[g];
   end

endmodule

`default_nettype wire

/* rtl/indexed_list_insert_remove_top.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Use:
//   Requests come in on the req_ stream (req_tuser = request code, req_tdata =
//   position and word). Each request gives exactly one response beat on the
//   rsp_ stream with the read or popped word, the new entry count and status.
//   Insert, remove and pop-at move every later entry at once: each cell
//   loads from its neighbor at the same edge.
//   A response is built in order: request registers, cell update with
//   registered hit capture, first OR level, result register.
//   Requests are taken one at a time: req_tready is high only while the
//   sequencer is idle, so a new request waits until the last one leaves it.
//   A finished response sits in the output register while req_tready is high
//   again, so a new request can enter while the receiver stalls; that request
//   then waits in its last step until the output register frees up.
//   Reset empties the list (count 0) and drops any pending response. Entry
//   contents are not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove_top #(
   parameter int CAPACITY = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // [7:0] position, [39:8] word_in
   input  wire  [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata    // [31:0] word_out, [38:32] count,
                                    // [40:39] status, [47:41] zero
);
   import ilir_pkg::*;

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = FILL_W + POS_W;

   // request decode
   logic [POS_W-1:0]        req_pos;
   logic signed [31:0]      req_word;
   logic [CMP_W-1:0]        pos_ext, fill_ext, epos_ext;
   logic                    full;
   cell_cmd_type            dec_cmd;
   status_type              dec_status;
   logic [FILL_W-1:0]       dec_fill;

   // registered request
   cell_cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic signed [31:0]      word_ff, word_in;
   status_type              status_ff, status_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;

   state_type               state_ff, state_in;
   logic                    exec_en, grp_load, rsp_load, accept;

   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0]             rsp_tdata_ff, rsp_tdata_in;

   cell_cmd_type            cell_cmd;
   logic [CAPACITY-1:0][31:0] entries;
   logic [CAPACITY-1:0][31:0] sels;
   logic signed [31:0]      gathered;

   assign req_pos  = req_tdata[7:0];
   assign req_word = req_tdata[39:8];
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      pos_ext    = CMP_W'(req_pos);
      fill_ext   = CMP_W'(fill_ff);
      full       = (fill_ext == CMP_W'(CAPACITY));
      epos_ext   = pos_ext;
      dec_cmd    = '{op: CELL_HOLD, rd: 1'b0};
      dec_status = STAT_OK;
      dec_fill   = fill_ff;
      case (req_code_type'(req_tuser))
         REQ_APPEND: begin
            if (full) dec_status = STAT_FULL;
            else begin
               dec_cmd.op = CELL_LOAD;
               epos_ext   = fill_ext;
               dec_fill   = fill_ff + FILL_W'(1);
            end
         end
         REQ_INSERT: begin
            if (full) dec_status = STAT_FULL;
            else if (pos_ext > fill_ext) dec_status = STAT_RANGE;
            else begin
               dec_cmd.op = CELL_INSERT;
               dec_fill   = fill_ff + FILL_W'(1);
            end
         end
         REQ_REMOVE: begin
            if (pos_ext >= fill_ext) dec_status = STAT_RANGE;
            else begin
               dec_cmd.op = CELL_DROP;
               dec_fill   = fill_ff - FILL_W'(1);
            end
         end
         REQ_POP_AT: begin
            if (pos_ext >= fill_ext) dec_status = STAT_RANGE;
            else begin
               dec_cmd.op = CELL_DROP;
               dec_cmd.rd = 1'b1;
               dec_fill   = fill_ff - FILL_W'(1);
            end
         end
         REQ_POP_LAST: begin
            if (fill_ff == '0) dec_status = STAT_RANGE;
            else begin
               dec_cmd.rd = 1'b1;
               epos_ext   = fill_ext - CMP_W'(1);
               dec_fill   = fill_ff - FILL_W'(1);
            end
         end
         REQ_READ: begin
            if (pos_ext >= fill_ext) dec_status = STAT_RANGE;
            else dec_cmd.rd = 1'b1;
         end
         REQ_WRITE: begin
            if (pos_ext >= fill_ext) dec_status = STAT_RANGE;
            else dec_cmd.op = CELL_LOAD;
         end
         default: begin
            dec_cmd = '{op: CELL_HOLD, rd: 1'b0};
         end
      endcase
   end

   // request registers; the count is settled at acceptance
   always_comb begin
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      word_in   = word_ff;
      status_in = status_ff;
      fill_in   = fill_ff;
      if (accept) begin
         cmd_in    = dec_cmd;
         pos_in    = epos_ext[IDX_W-1:0];
         word_in   = req_word;
         status_in = dec_status;
         fill_in   = dec_fill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cmd_ff  <= '{op: CELL_HOLD, rd: 1'b0};
      end else begin
         fill_ff <= fill_in;
         cmd_ff  <= cmd_in;
      end
      pos_ff    <= pos_in;
      word_ff   <= word_in;
      status_ff <= status_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_GATHER;
         ST_GATHER: state_in = ST_FINISH;
         ST_FINISH: if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      exec_en    = (state_ff == ST_EXEC);
      grp_load   = (state_ff == ST_GATHER);
      rsp_load   = (state_ff == ST_FINISH) && (!rsp_tvalid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // cell row
   assign cell_cmd = exec_en ? cmd_ff : cell_cmd_type'{op: CELL_HOLD, rd: 1'b0};

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [31:0] below, above;
      if (k == 0) begin : g_first
         assign below = '0;
      end else begin : g_mid_lo
         assign below = entries[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign above = '0;
      end else begin : g_mid_hi
         assign above = entries[k+1];
      end
      ilir_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (k)
      ) u_cell (
         .clock (clock),
         .cmd   (cell_cmd),
         .pos   (pos_ff),
         .word  (word_ff),
         .below (below),
         .above (above),
         .entry (entries[k]),
         .sel   (sels[k])
      );
   end

   ilir_gather #(
      .CAPACITY (CAPACITY)
   ) u_gather (
      .clock (clock),
      .load  (grp_load),
      .sel   (sels),
      .word  (gathered)
   );

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {7'd0, status_ff, COUNT_W'(fill_ff), gathered};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else       rsp_tvalid_ff <= rsp_tvalid_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff) <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[40:39] != STAT_OK) |-> (rsp_tdata[31:0] == '0))
      else $error("failed request returned a nonzero word");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not start");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("response overwrote a pending beat");

endmodule

`default_nettype wire

/* test/tb_indexed_list_insert_remove_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove_top
// Self-checking bench for the shifting-cell ordered list. A mirror of the
// list predicts the word, count and status of every response. Stimulus is a
// short directed pass over empty, range and spare-code cases, followed by
// random grow and shrink sweeps that run the list from empty to full and back
// with random idling on both streams. One long receiver stall backs up the
// block while requests keep coming.
// ----------------------------------------------------------------------------

module tb_indexed_list_insert_remove_top;
   import ilir_pkg::*;

   localparam int          LIST_DEPTH   = 64;
   localparam int          RANDOM_ITEMS = 400;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          HOLD_CYCLES  = 250;
   localparam logic [2:0]  REQ_SPARE    = 3'd7;   // undefined code, must be a no-op

   typedef struct packed {
      logic signed [31:0] word;
      logic [6:0]         count;
      status_type         status;
   } list_result_type;

   class list_scoreboard;
      logic signed [31:0] slots [LIST_DEPTH];
      int unsigned        used;
      list_result_type    due_q [$];
      int unsigned        mismatches;

      function void drop_slot(input int unsigned at);
         int unsigned k;
         for (k = at; k + 1 < used; k++)
            slots[k] = slots[k + 1];
         used--;
      endfunction

      // works out the response of one accepted request and updates the mirror
      function void note_request(input logic [2:0] code, input logic [7:0] pos,
                                 input logic signed [31:0] word);
         list_result_type r;
         int unsigned     k;
         r.word   = '0;
         r.status = STAT_OK;
         case (code)
            REQ_APPEND: begin
               if (used >= LIST_DEPTH) r.status = STAT_FULL;
               else begin
                  slots[used] = word;
                  used++;
               end
            end
            REQ_INSERT: begin
               // fullness wins over a bad position
               if (used >= LIST_DEPTH) r.status = STAT_FULL;
               else if (pos > used) r.status = STAT_RANGE;
               else begin
                  for (k = used; k > pos; k--)
                     slots[k] = slots[k - 1];
                  slots[pos] = word;
                  used++;
               end
            end
            REQ_REMOVE: begin
               if (pos >= used) r.status = STAT_RANGE;
               else drop_slot(pos);
            end
            REQ_POP_AT: begin
               if (pos >= used) r.status = STAT_RANGE;
               else begin
                  r.word = slots[pos];
                  drop_slot(pos);
               end
            end
            REQ_POP_LAST: begin
               if (used == 0) r.status = STAT_RANGE;
               else begin
                  r.word = slots[used - 1];
                  used--;
               end
            end
            REQ_READ: begin
               if (pos >= used) r.status = STAT_RANGE;
               else r.word = slots[pos];
            end
            REQ_WRITE: begin
               if (pos >= used) r.status = STAT_RANGE;
               else slots[pos] = word;
            end
            default: ;
         endcase
         r.count = used[6:0];
         due_q.push_back(r);
      endfunction

      function void check_response(input logic [47:0] beat);
         list_result_type want;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response beat %h with nothing outstanding", $realtime, beat);
            return;
         end
         want = due_q.pop_front();
         if (beat[31:0] !== want.word || beat[38:32] !== want.count ||
             beat[40:39] !== want.status || beat[47:41] !== 7'd0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: word %h/%h count %0d/%0d status %0d/%0d pad %h (exp/got)",
                        $realtime, want.word, beat[31:0], want.count, beat[38:32],
                        want.status, beat[40:39], beat[47:41]);
         end
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // [7:0] position, [39:8] word_in
   logic [2:0]  req_tuser;    // [2:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [31:0] word_out, [38:32] count, [40:39] status

   list_scoreboard board = new();

   bit          quiet;        // no idling on either side while set
   bit          hold_req;
   bit          hold_done;
   int          hold_left;
   bit          growing;
   int unsigned cycles;

   indexed_list_insert_remove_top #(.CAPACITY(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata);
      if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= quiet || ($urandom_range(99) >= 18);
   end

   task automatic offer(input logic [2:0] code, input logic [7:0] pos,
                        input logic [31:0] word);
      while (!quiet && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {word, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(code, pos, word);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // mostly a live position; now and then one out of range, anywhere up to 255
   function automatic logic [7:0] aim(input bit may_equal);
      int unsigned top;
      logic [7:0]  p;
      top = board.used + (may_equal ? 1 : 0);
      if (top == 0 || $urandom_range(99) < 8) p = 8'($urandom_range(255, top));
      else p = 8'($urandom_range(top - 1, 0));
      return p;
   endfunction

   task automatic random_item();
      int unsigned roll;
      logic [2:0]  code;
      logic [7:0]  pos;
      roll = $urandom_range(99);
      if (growing && board.used == LIST_DEPTH && $urandom_range(2) == 0)
         growing = 1'b0;
      else if (!growing && board.used == 0)
         growing = 1'b1;
      if (roll >= 90) begin
         // noise: any code, any position
         code = 3'($urandom_range(7));
         pos  = 8'($urandom_range(255));
      end else if (growing) begin
         if (roll < 45) code = REQ_APPEND;
         else if (roll < 80) code = REQ_INSERT;
         else code = roll[0] ? REQ_READ : REQ_WRITE;
         pos = aim(code == REQ_INSERT);
      end else begin
         if (roll < 30) code = REQ_POP_AT;
         else if (roll < 55) code = REQ_REMOVE;
         else if (roll < 75) code = REQ_POP_LAST;
         else code = roll[0] ? REQ_READ : REQ_WRITE;
         pos = aim(1'b0);
      end
      offer(code, pos, pick_word());
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_APPEND;
      rsp_tready = 1'b0;
      growing    = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: everything positional is out of range
      offer(REQ_POP_LAST, 8'd0,   32'h0);
      offer(REQ_READ,     8'd0,   32'h0);
      offer(REQ_REMOVE,   8'd0,   32'h0);
      offer(REQ_POP_AT,   8'd0,   32'h0);
      offer(REQ_WRITE,    8'd0,   32'h1234_5678);
      offer(REQ_SPARE,    8'd255, 32'hFFFF_FFFF);
      offer(REQ_INSERT,   8'd1,   32'h1);
      // build a short list; insert at the count appends
      offer(REQ_INSERT,   8'd0,   32'h8000_0000);
      offer(REQ_APPEND,   8'd0,   32'h7FFF_FFFF);
      offer(REQ_INSERT,   8'd2,   32'h0);
      offer(REQ_INSERT,   8'd1,   32'h5A5A_5A5A);
      offer(REQ_INSERT,   8'd5,   32'h2);
      offer(REQ_READ,     8'd3,   32'h0);
      offer(REQ_READ,     8'd4,   32'h0);
      offer(REQ_WRITE,    8'd2,   32'hFFFF_FFFF);
      offer(REQ_READ,     8'd2,   32'h0);
      offer(REQ_POP_AT,   8'd1,   32'h0);
      offer(REQ_REMOVE,   8'd0,   32'h0);
      offer(REQ_READ,     8'd255, 32'h0);
      offer(REQ_WRITE,    8'd255, 32'hA5A5_A5A5);
      offer(REQ_POP_LAST, 8'd0,   32'h0);
      offer(REQ_POP_AT,   8'd0,   32'h0);
      offer(REQ_SPARE,    8'd0,   32'h0);
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 60) hold_req <= 1'b1;
         if (i == 200) quiet <= 1'b1;
         if (i == 280) quiet <= 1'b0;
         if (i == 320) drain();
         random_item();
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
